// ===== hw/rtl/fcc8_pkg.sv =====
// ----------------------------------------------------------------------------
// fcc8_pkg
// shared types and constants of the crc-8 frame checker
// ----------------------------------------------------------------------------
package fcc8_pkg;

    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CRC_INIT  = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h07;
    localparam logic [LEN_W-1:0]  CAP_RESET = 6'd32;

    localparam logic [1:0] T_START   = 2'd0;
    localparam logic [1:0] T_REGULAR = 2'd1;
    localparam logic [1:0] T_END     = 2'd2;
    localparam logic [1:0] T_SIMPLE  = 2'd3;

    typedef enum logic [2:0] {
        S_OK        = 3'd0,
        S_OK_END    = 3'd1,
        S_OK_SIMPLE = 3'd2,
        S_CRC       = 3'd3,
        S_BROKEN    = 3'd4,
        S_NOROOM    = 3'd5,
        S_LENERR    = 3'd6
    } status_t;

    // result request from parser to payload buffer
    typedef struct packed {
        logic             single;
        logic             drain;
        logic [1:0]       ftype;
        status_t          status;
        logic [LEN_W-1:0] len;
    } res_t;

    // payload write request
    typedef struct packed {
        logic              en;
        logic [LEN_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } wr_t;

endpackage

// ===== hw/rtl/fcc8_parser.sv =====
// ----------------------------------------------------------------------------
// fcc8_parser
// header, payload and checksum parsing with crc-8 and run tracking
// ----------------------------------------------------------------------------
module fcc8_parser #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [fcc8_pkg::LEN_W-1:0]  cfg_data,
    input  logic                        item_valid,
    input  logic [fcc8_pkg::BYTE_W-1:0] item_byte,
    input  logic                        item_begin,
    input  logic                        drain_busy,
    input  logic                        out_free,
    output logic                        item_take,
    output fcc8_pkg::res_t              res,
    output fcc8_pkg::wr_t               wr
);

    localparam logic [fcc8_pkg::LEN_W-1:0] MAX_LEN = fcc8_pkg::LEN_W'(PAYLOAD_MAX);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    phase_t                      phase_reg;
    phase_t                      phase_next;
    logic [fcc8_pkg::BYTE_W-1:0] header_reg;
    logic [fcc8_pkg::BYTE_W-1:0] crc_reg;
    logic [fcc8_pkg::LEN_W-1:0]  cnt_reg;
    logic                        start_flag_reg;
    logic                        start_flag_next;
    logic [fcc8_pkg::LEN_W-1:0]  cap_reg;

    logic [fcc8_pkg::LEN_W-1:0]  new_len;
    logic [1:0]                  new_type;
    logic [fcc8_pkg::LEN_W-1:0]  cur_len;
    logic [1:0]                  cur_type;
    logic [fcc8_pkg::LEN_W-1:0]  cnt_inc;
    logic [fcc8_pkg::BYTE_W-1:0] crc_hdr;
    logic [fcc8_pkg::BYTE_W-1:0] crc_pay;
    fcc8_pkg::res_t              res_d;

    function automatic logic [fcc8_pkg::BYTE_W-1:0] crc8_step(
        input logic [fcc8_pkg::BYTE_W-1:0] crc,
        input logic [fcc8_pkg::BYTE_W-1:0] b
    );
        logic [fcc8_pkg::BYTE_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < fcc8_pkg::BYTE_W; i++)
        begin
            if (v[fcc8_pkg::BYTE_W-1])
                v = {v[fcc8_pkg::BYTE_W-2:0], 1'b0} ^ fcc8_pkg::CRC_POLY;
            else
                v = {v[fcc8_pkg::BYTE_W-2:0], 1'b0};
        end
        return v;
    endfunction

    assign new_len  = item_byte[fcc8_pkg::LEN_W-1:0];
    assign new_type = item_byte[7:6];
    assign cur_len  = header_reg[fcc8_pkg::LEN_W-1:0];
    assign cur_type = header_reg[7:6];
    assign cnt_inc  = cnt_reg + 1'b1;
    assign crc_hdr  = crc8_step(fcc8_pkg::CRC_INIT, item_byte);
    assign crc_pay  = crc8_step(crc_reg, item_byte);

    // decode of the byte held in the input register
    always_comb
    begin
        res_d           = '0;
        res_d.status    = fcc8_pkg::S_OK;
        res_d.len       = cur_len;
        res_d.ftype     = cur_type;
        phase_next      = PH_IDLE;
        start_flag_next = start_flag_reg;
        if (item_begin)
        begin
            res_d.ftype = new_type;
            if (new_len > MAX_LEN)
            begin
                res_d.single = 1'b1;
                res_d.status = fcc8_pkg::S_LENERR;
            end
            else if (new_len > cap_reg)
            begin
                res_d.single = 1'b1;
                res_d.status = fcc8_pkg::S_NOROOM;
            end
            else if (new_len == '0)
                phase_next = PH_CHECK;
            else
                phase_next = PH_PAYLOAD;
        end
        else
        begin
            unique case (phase_reg)
                PH_PAYLOAD:
                begin
                    phase_next = (cnt_inc >= cur_len) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_CHECK:
                begin
                    if (crc_reg != item_byte)
                    begin
                        res_d.single = 1'b1;
                        res_d.status = fcc8_pkg::S_CRC;
                    end
                    else if ((cur_type == fcc8_pkg::T_START ||
                              cur_type == fcc8_pkg::T_SIMPLE) && start_flag_reg)
                    begin
                        start_flag_next = 1'b0;
                        res_d.single    = 1'b1;
                        res_d.status    = fcc8_pkg::S_BROKEN;
                    end
                    else
                    begin
                        case (cur_type)
                            fcc8_pkg::T_START:
                            begin
                                start_flag_next = 1'b1;
                                res_d.status    = fcc8_pkg::S_OK;
                            end
                            fcc8_pkg::T_END:
                            begin
                                start_flag_next = 1'b0;
                                res_d.status    = fcc8_pkg::S_OK_END;
                            end
                            fcc8_pkg::T_SIMPLE:
                                res_d.status = fcc8_pkg::S_OK_SIMPLE;
                            default:
                                res_d.status = fcc8_pkg::S_OK;
                        endcase
                        if (cur_len == '0)
                            res_d.single = 1'b1;
                        else
                            res_d.drain = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign item_take = item_valid && !drain_busy && (!res_d.single || out_free);

    always_comb
    begin
        res        = res_d;
        res.single = res_d.single && item_take;
        res.drain  = res_d.drain && item_take;
        wr.en      = item_take && !item_begin && (phase_reg == PH_PAYLOAD) &&
                     (cnt_reg < MAX_LEN);
        wr.addr    = cnt_reg;
        wr.data    = item_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            header_reg     <= '0;
            crc_reg        <= fcc8_pkg::CRC_INIT;
            cnt_reg        <= '0;
            start_flag_reg <= 1'b0;
            cap_reg        <= fcc8_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_valid)
                cap_reg <= cfg_data;
            if (item_take)
            begin
                phase_reg      <= phase_next;
                start_flag_reg <= start_flag_next;
                if (item_begin)
                begin
                    header_reg <= item_byte;
                    cnt_reg    <= '0;
                    crc_reg    <= crc_hdr;
                end
                else if (phase_reg == PH_PAYLOAD)
                begin
                    cnt_reg <= cnt_inc;
                    crc_reg <= crc_pay;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/fcc8_payload_buf.sv =====
// ----------------------------------------------------------------------------
// fcc8_payload_buf
// payload memory, drain sequencer and output register
// ----------------------------------------------------------------------------
module fcc8_payload_buf #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcc8_pkg::wr_t               wr,
    input  fcc8_pkg::res_t              res,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [fcc8_pkg::BYTE_W-1:0] out_byte,
    output logic                        out_has,
    output logic [1:0]                  out_type,
    output fcc8_pkg::status_t           out_status,
    output logic                        out_last,
    output logic                        drain_busy,
    output logic                        out_free
);

    localparam int ADDR_W = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [fcc8_pkg::BYTE_W-1:0] mem [PAYLOAD_MAX];

    logic                        busy_reg;
    logic [fcc8_pkg::LEN_W-1:0]  idx_reg;
    logic [fcc8_pkg::LEN_W-1:0]  len_reg;
    logic [1:0]                  dtype_reg;
    fcc8_pkg::status_t           dstatus_reg;
    logic                        out_valid_reg;
    logic [fcc8_pkg::BYTE_W-1:0] out_byte_reg;
    logic                        out_has_reg;
    logic [1:0]                  out_type_reg;
    fcc8_pkg::status_t           out_status_reg;
    logic                        out_last_reg;
    logic                        drain_step;
    logic                        drain_end;

    assign out_free   = !out_valid_reg || out_ready;
    assign drain_step = busy_reg && out_free;
    assign drain_end  = (idx_reg + 1'b1) == len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res.drain)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (drain_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (drain_end)
                    busy_reg <= 1'b0;
            end
            if (drain_step || res.single)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // memory, drain and output data registers
    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        if (res.drain)
        begin
            len_reg     <= res.len;
            dtype_reg   <= res.ftype;
            dstatus_reg <= res.status;
        end
        if (drain_step)
        begin
            out_byte_reg   <= mem[idx_reg[ADDR_W-1:0]];
            out_has_reg    <= 1'b1;
            out_type_reg   <= dtype_reg;
            out_status_reg <= dstatus_reg;
            out_last_reg   <= drain_end;
        end
        else if (res.single)
        begin
            out_byte_reg   <= '0;
            out_has_reg    <= 1'b0;
            out_type_reg   <= res.ftype;
            out_status_reg <= res.status;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_has    = out_has_reg;
    assign out_type   = out_type_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;
    assign drain_busy = busy_reg;

endmodule

// ===== hw/rtl/frame_checker_crc8_unit.sv =====
// ----------------------------------------------------------------------------
// frame_checker_crc8_unit
// byte-serial deframer checking crc-8 frames and releasing good payloads
//
//   channel   direction  signals                      contents
//   s_*       in         s_tvalid s_tready s_tdata    frame bytes
//                        s_tuser                      header marker
//   m_*       out        m_tvalid m_tready m_tdata    payload bytes and status
//                        m_tuser m_tlast              data flag, frame kind
//   cfg_*     in         cfg_valid cfg_ready cfg_data receiver capacity
//
// one frame byte per cycle through the input register and parser while no
// drain runs; a good frame with n payload bytes drains n results, one per
// cycle while the output is free, from the payload memory after the checksum
// reset is asynchronous; the payload memory is not cleared
// with no drain and a stalled output, bytes releasing no result keep flowing
// ----------------------------------------------------------------------------
module frame_checker_crc8_unit #(
    parameter int PAYLOAD_MAX = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // in_byte
    input  logic                       s_tuser,   // frame_begin
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // out_byte, status, zero fill
    output logic [2:0]                 m_tuser,   // has_data, frame_kind
    output logic                       m_tlast,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [fcc8_pkg::LEN_W-1:0] cfg_data
);

    logic                        in_valid_reg;
    logic [fcc8_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_begin_reg;
    logic                        item_take;
    logic                        drain_busy;
    logic                        out_free;
    fcc8_pkg::res_t              res;
    fcc8_pkg::wr_t               wr;
    logic [fcc8_pkg::BYTE_W-1:0] out_byte;
    logic                        out_has;
    logic [1:0]                  out_type;
    fcc8_pkg::status_t           out_status;

    assign s_tready  = !in_valid_reg || item_take;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata;
            in_begin_reg <= s_tuser;
        end
    end

    fcc8_parser #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .item_begin (in_begin_reg),
        .drain_busy (drain_busy),
        .out_free   (out_free),
        .item_take  (item_take),
        .res        (res),
        .wr         (wr)
    );

    fcc8_payload_buf #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .res        (res),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_byte   (out_byte),
        .out_has    (out_has),
        .out_type   (out_type),
        .out_status (out_status),
        .out_last   (m_tlast),
        .drain_busy (drain_busy),
        .out_free   (out_free)
    );

    assign m_tdata = {5'b0, out_status, out_byte};
    assign m_tuser = {out_type, out_has};

endmodule

// ===== hw/rtl/fcc8_checker.sv =====
// ----------------------------------------------------------------------------
// fcc8_checker
// port-level checks of the crc-8 frame checker
// ----------------------------------------------------------------------------
module fcc8_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // status-only results carry a zero byte
    a_nodata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
        else $error("status result with nonzero byte");

    // status-only results close the frame
    a_nodata_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("status result without last");

    // ok_end only on end frames
    a_end_type: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[10:8] == fcc8_pkg::S_OK_END |->
        m_tuser[2:1] == fcc8_pkg::T_END)
        else $error("ok_end on non-end frame");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind frame_checker_crc8_unit fcc8_checker u_fcc8_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_ready (cfg_ready)
);
